[rtl/core/tco_pkg.sv]
// Shared types and constants for the TTL handle cache.
package tco_pkg;

  localparam int unsigned Capacity = 256;
  localparam logic [31:0] TtlReset = 32'd5000;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned KeyW     = 256;

  typedef enum logic [2:0] {
    OUT_HIT      = 3'd0,
    OUT_MISS     = 3'd1,
    OUT_STALE    = 3'd2,
    OUT_STORED   = 3'd3,
    OUT_REJECTED = 3'd4
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_SCAN,
    ST_LK_DONE,
    ST_IN_PURGE,
    ST_IN_EVICT,
    ST_IN_EVDROP,
    ST_IN_FIND,
    ST_IN_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        action;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [62:0] now_ms;
    logic [62:0] token_expiry_ms;
    logic        eligible;
    logic [31:0] context_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] context_out;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] expiry;
    logic [TimeW-1:0] created;
    logic [31:0]      handle;
  } entry_t;

endpackage

[rtl/core/tco_store.sv]
// Entry memory with a registered read and a flop valid vector.
module tco_store #(
  parameter int unsigned Capacity = tco_pkg::Capacity,
  localparam int unsigned IdxW = $clog2(Capacity)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW-1:0]      rd_addr_i,
  output tco_pkg::entry_t      rd_data_o,
  output logic                 rd_valid_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  tco_pkg::entry_t      wr_data_i,
  input  logic                 set_en_i,
  input  logic                 clr_en_i,
  input  logic [IdxW-1:0]      vld_addr_i
);

  tco_pkg::entry_t mem_q [Capacity];
  logic [Capacity-1:0] valid_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (set_en_i) valid_q[vld_addr_i] <= 1'b1;
      if (clr_en_i) valid_q[vld_addr_i] <= 1'b0;
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;

endmodule

[rtl/core/tco_ctrl.sv]
// Sequencer that sweeps the entry memory for lookups and inserts.
module tco_ctrl #(
  parameter int unsigned Capacity = tco_pkg::Capacity,
  localparam int unsigned IdxW = $clog2(Capacity),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tco_pkg::req_t    req_i,
  input  logic [31:0]      ttl_ms_i,
  output logic             busy_o,
  output logic             done_o,
  output tco_pkg::rsp_t    rsp_o,
  output logic [IdxW-1:0]  rd_addr_o,
  input  tco_pkg::entry_t  rd_data_i,
  input  logic             rd_valid_i,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output tco_pkg::entry_t  wr_data_o,
  output logic             set_en_o,
  output logic             clr_en_o,
  output logic [IdxW-1:0]  vld_addr_o
);

  localparam logic [CntW-1:0] CapC = CntW'(Capacity);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Capacity - 1);

  tco_pkg::state_e state_q, state_d;
  tco_pkg::req_t   req_q, req_d;
  logic [62:0]     exp_q, exp_d;
  logic [IdxW:0]   ptr_q, ptr_d;       // issued read address, top bit marks sweep end
  logic            rv_q, rv_d;         // a read is in flight
  logic [IdxW-1:0] rix_q, rix_d;       // index of the data now returning
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hix_q, hix_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] fix_q, fix_d;
  logic            old_q, old_d;
  logic [IdxW-1:0] oix_q, oix_d;
  logic [62:0]     oct_q, oct_d;
  tco_pkg::rsp_t   rsp_q, rsp_d;
  logic            done_q, done_d;

  logic            key_eq, stale;
  logic [63:0]     sum;
  logic [62:0]     exp_c;

  assign key_eq = rd_valid_i && rd_data_i.key ==
                  {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
  assign stale  = rd_data_i.expiry <= req_q.now_ms;

  always_comb begin
    sum   = {1'b0, req_i.now_ms} + {32'd0, ttl_ms_i};
    exp_c = sum[63] ? {63{1'b1}} : sum[62:0];
    if (req_i.token_expiry_ms != '0 && req_i.token_expiry_ms < exp_c) begin
      exp_c = req_i.token_expiry_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tco_pkg::ST_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    exp_q  <= exp_d;
    rix_q  <= rix_d;
    hit_q  <= hit_d;
    hix_q  <= hix_d;
    free_q <= free_d;
    fix_q  <= fix_d;
    old_q  <= old_d;
    oix_q  <= oix_d;
    oct_q  <= oct_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    req_d = req_q; exp_d = exp_q; ptr_d = ptr_q; rv_d = 1'b0; rix_d = ptr_q[IdxW-1:0];
    cnt_d = cnt_q; hit_d = hit_q; hix_d = hix_q; free_d = free_q; fix_d = fix_q;
    old_d = old_q; oix_d = oix_q; oct_d = oct_q; rsp_d = rsp_q; done_d = 1'b0;
    rd_addr_o = ptr_q[IdxW-1:0];
    wr_en_o = 1'b0; wr_addr_o = hix_q; wr_data_o = '0;
    set_en_o = 1'b0; clr_en_o = 1'b0; vld_addr_o = rix_q;

    // issue the next read while a sweep is running
    if (state_q == tco_pkg::ST_LK_SCAN || state_q == tco_pkg::ST_IN_PURGE ||
        state_q == tco_pkg::ST_IN_EVICT || state_q == tco_pkg::ST_IN_FIND) begin
      if (!ptr_q[IdxW]) begin
        rv_d  = 1'b1;
        ptr_d = (ptr_q[IdxW-1:0] == LastIdx) ? {1'b1, {IdxW{1'b0}}} : ptr_q + 1'b1;
      end
    end

    unique case (state_q)
      tco_pkg::ST_IDLE: begin
        if (start_i) begin
          req_d = req_i; exp_d = exp_c; ptr_d = '0;
          hit_d = 1'b0; free_d = 1'b0; old_d = 1'b0;
          if (!req_i.action) begin
            if (!req_i.eligible) begin
              rsp_d = '{outcome: tco_pkg::OUT_MISS, context_out: '0};
              state_d = tco_pkg::ST_RESP;
            end else begin
              state_d = tco_pkg::ST_LK_SCAN;
            end
          end else if (!req_i.eligible || exp_c <= req_i.now_ms) begin
            rsp_d = '{outcome: tco_pkg::OUT_REJECTED, context_out: '0};
            state_d = tco_pkg::ST_RESP;
          end else begin
            state_d = tco_pkg::ST_IN_PURGE;
          end
        end
      end
      tco_pkg::ST_LK_SCAN: begin
        if (rv_q && key_eq && !hit_q) begin
          hit_d = 1'b1; hix_d = rix_q;
          if (stale) begin
            clr_en_o = 1'b1;
            if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            rsp_d = '{outcome: tco_pkg::OUT_STALE, context_out: '0};
          end else begin
            rsp_d = '{outcome: tco_pkg::OUT_HIT, context_out: rd_data_i.handle};
          end
        end
        if (!rv_q && ptr_q[IdxW]) state_d = tco_pkg::ST_LK_DONE;
      end
      tco_pkg::ST_LK_DONE: begin
        if (!hit_q) rsp_d = '{outcome: tco_pkg::OUT_MISS, context_out: '0};
        state_d = tco_pkg::ST_RESP;
      end
      tco_pkg::ST_IN_PURGE: begin
        if (rv_q && rd_valid_i && stale) begin
          clr_en_o = 1'b1;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
        if (!rv_q && ptr_q[IdxW]) begin
          ptr_d = '0;
          state_d = (cnt_d >= CapC) ? tco_pkg::ST_IN_EVICT : tco_pkg::ST_IN_FIND;
          old_d = 1'b0;
        end
      end
      tco_pkg::ST_IN_EVICT: begin
        if (rv_q && rd_valid_i && (!old_q || rd_data_i.created < oct_q)) begin
          old_d = 1'b1; oix_d = rix_q; oct_d = rd_data_i.created;
        end
        if (!rv_q && ptr_q[IdxW]) state_d = tco_pkg::ST_IN_EVDROP;
      end
      tco_pkg::ST_IN_EVDROP: begin
        vld_addr_o = oix_q;
        if (old_q) begin
          clr_en_o = 1'b1;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end else begin
          cnt_d = '0;
        end
        ptr_d = '0; old_d = 1'b0;
        state_d = (old_q && cnt_d >= CapC) ? tco_pkg::ST_IN_EVICT : tco_pkg::ST_IN_FIND;
      end
      tco_pkg::ST_IN_FIND: begin
        if (rv_q) begin
          if (key_eq && !hit_q) begin
            hit_d = 1'b1; hix_d = rix_q;
          end
          if (!rd_valid_i && !free_q) begin
            free_d = 1'b1; fix_d = rix_q;
          end
        end
        if (!rv_q && ptr_q[IdxW]) state_d = tco_pkg::ST_IN_WRITE;
      end
      tco_pkg::ST_IN_WRITE: begin
        wr_data_o.key     = {req_q.key_word3, req_q.key_word2,
                             req_q.key_word1, req_q.key_word0};
        wr_data_o.expiry  = exp_q;
        wr_data_o.created = req_q.now_ms;
        wr_data_o.handle  = req_q.context_in;
        if (hit_q) begin
          wr_en_o = 1'b1; wr_addr_o = hix_q;
        end else if (free_q) begin
          wr_en_o = 1'b1; wr_addr_o = fix_q;
          set_en_o = 1'b1; vld_addr_o = fix_q;
          cnt_d = cnt_q + 1'b1;
        end
        rsp_d = '{outcome: tco_pkg::OUT_STORED, context_out: '0};
        state_d = tco_pkg::ST_RESP;
      end
      tco_pkg::ST_RESP: begin
        done_d = 1'b1;
        state_d = tco_pkg::ST_IDLE;
      end
      default: state_d = tco_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = state_q != tco_pkg::ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/core/ttl_cache_oldest_evict_top.sv]
// Top level of the TTL handle cache: APB register, sequencer and entry memory.
// One item is taken when start_i is high and busy_o low; its single result
// appears for one cycle with done_o high and cannot be held off. A lookup
// sweeps the entry memory once, and an ineligible or rejected item skips the
// sweep; an insert sweeps the entry memory once to purge, once more per
// eviction while full, and once to find the key or a free slot.
module ttl_cache_oldest_evict_top #(
  parameter int unsigned Capacity = tco_pkg::Capacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tco_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output tco_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned IdxW = $clog2(Capacity);

  logic [31:0] ttl_q;
  logic [IdxW-1:0] rd_addr, wr_addr, vld_addr;
  tco_pkg::entry_t rd_data, wr_data;
  logic rd_valid, wr_en, set_en, clr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= tco_pkg::TtlReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      ttl_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? ttl_q : '0;

  tco_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_i, .ttl_ms_i(ttl_q),
    .busy_o, .done_o, .rsp_o,
    .rd_addr_o(rd_addr), .rd_data_i(rd_data), .rd_valid_i(rd_valid),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .set_en_o(set_en), .clr_en_o(clr_en), .vld_addr_o(vld_addr)
  );

  tco_store #(.Capacity(Capacity)) u_store (
    .clk_i, .rst_ni,
    .rd_addr_i(rd_addr), .rd_data_o(rd_data), .rd_valid_o(rd_valid),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .set_en_i(set_en), .clr_en_i(clr_en), .vld_addr_i(vld_addr)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the TTL handle cache with oldest-first eviction.
module tb;
  import tco_pkg::*;

  localparam logic [1:0]  RegTtl   = 2'd0;
  localparam logic [62:0] TimeTop  = {63{1'b1}};
  localparam int          NumKeys  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o, done_o;
  rsp_t        rsp_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ttl_cache_oldest_evict_top u_top (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the cache contents
  logic [31:0]  ttl_shadow;
  bit           slot_live [Capacity];
  logic [255:0] slot_key  [Capacity];
  logic [62:0]  slot_exp  [Capacity];
  logic [62:0]  slot_born [Capacity];
  logic [31:0]  slot_hnd  [Capacity];
  int unsigned  live_total;

  rsp_t         pending_rsp [$];
  int           errors = 0;
  int           beats_out = 0;
  int           n_hit = 0, n_stale = 0, n_evict = 0;
  logic [255:0] key_pool [NumKeys];

  typedef struct {
    req_t     rq;
    bit       typed;
    outcome_e oc;
    logic [31:0] cx;
  } row_t;
  row_t directed [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int find_slot(logic [255:0] k);
    for (int i = 0; i < Capacity; i++)
      if (slot_live[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    if (slot_live[i]) begin
      slot_live[i] = 1'b0;
      if (live_total > 0) live_total--;
    end
  endfunction

  function automatic rsp_t predict_cache(req_t r);
    rsp_t         o;
    logic [255:0] k;
    logic [63:0]  sum;
    logic [62:0]  expiry;
    int           s, oldest;
    o = '0;
    k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
    if (!r.action) begin
      s = r.eligible ? find_slot(k) : -1;
      if (s < 0) o.outcome = OUT_MISS;
      else if (slot_exp[s] <= r.now_ms) begin
        drop_slot(s);
        o.outcome = OUT_STALE;
        n_stale++;
      end else begin
        o.outcome = OUT_HIT;
        o.context_out = slot_hnd[s];
        n_hit++;
      end
    end else if (!r.eligible) begin
      o.outcome = OUT_REJECTED;
    end else begin
      sum = {1'b0, r.now_ms} + {32'd0, ttl_shadow};
      expiry = sum[63] ? TimeTop : sum[62:0];
      if (r.token_expiry_ms != '0 && r.token_expiry_ms < expiry) expiry = r.token_expiry_ms;
      if (expiry <= r.now_ms) o.outcome = OUT_REJECTED;
      else begin
        for (int i = 0; i < Capacity; i++)
          if (slot_live[i] && slot_exp[i] <= r.now_ms) drop_slot(i);
        while (live_total >= Capacity) begin
          oldest = -1;
          for (int i = 0; i < Capacity; i++)
            if (slot_live[i] && (oldest < 0 || slot_born[i] < slot_born[oldest])) oldest = i;
          if (oldest < 0) begin
            live_total = 0;
            break;
          end
          drop_slot(oldest);
          n_evict++;
        end
        s = find_slot(k);
        if (s < 0) begin
          for (int i = 0; i < Capacity; i++)
            if (!slot_live[i]) begin
              s = i;
              break;
            end
          if (s >= 0) begin
            slot_live[s] = 1'b1;
            live_total++;
          end
        end
        if (s >= 0) begin
          slot_key[s]  = k;
          slot_exp[s]  = expiry;
          slot_born[s] = r.now_ms;
          slot_hnd[s]  = r.context_in;
        end
        o.outcome = OUT_STORED;
      end
    end
    return o;
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      beats_out++;
      if (pending_rsp.size() == 0) report("unexpected result", rsp_o.outcome, '0);
      else begin
        if (rsp_o.outcome !== pending_rsp[0].outcome)
          report("outcome", rsp_o.outcome, pending_rsp[0].outcome);
        if (rsp_o.context_out !== pending_rsp[0].context_out)
          report("context_out", rsp_o.context_out, pending_rsp[0].context_out);
        void'(pending_rsp.pop_front());
      end
    end
  end

  // Drive one item from the falling edge; busy_o is settled there
  task automatic send_item(req_t r, bit typed, rsp_t want, int gap);
    rsp_t p;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i   <= r;
    start_i <= 1'b1;
    while (busy_o) @(negedge clk_i);
    p = predict_cache(r);
    pending_rsp.push_back(typed ? want : p);
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= RegTtl; pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (!wr && prdata !== ttl_shadow) report("ttl readback", prdata, ttl_shadow);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_ttl(logic [31:0] v);
    @(negedge clk_i);
    apb_access(1'b1, v);
    ttl_shadow = v;
    apb_access(1'b0, '0);
  endtask

  function automatic void add_row(bit act, logic [255:0] k, logic [62:0] now,
                                  logic [62:0] tok, bit el, logic [31:0] ctx,
                                  bit typed, outcome_e oc, logic [31:0] cx);
    row_t w;
    w.rq = '{action: act, key_word0: k[63:0], key_word1: k[127:64],
             key_word2: k[191:128], key_word3: k[255:192], now_ms: now,
             token_expiry_ms: tok, eligible: el, context_in: ctx};
    w.typed = typed; w.oc = oc; w.cx = cx;
    directed.push_back(w);
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[62:0];
  endfunction

  initial begin
    logic [255:0] k1, kone;
    logic [62:0]  base;
    logic [31:0]  ttl_list [4];
    int           phase_len [4];
    int           item_no;
    int           gap;
    req_t         r;
    rsp_t         w;

    ttl_shadow = TtlReset;
    live_total = 0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    foreach (key_pool[i])
      key_pool[i] = {$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()};
    k1   = 256'h0123_4567_89ab_cdef_fedc_ba98_7654_3210_0f1e_2d3c_4b5a_6978_8796_a5b4_c3d2_e1f0;
    kone = '1;

    add_row(0, k1, 0, 0, 1, 0, 1, OUT_MISS, 0);
    add_row(1, k1, 100, 0, 0, 7, 1, OUT_REJECTED, 0);
    add_row(1, k1, 100, 0, 1, 32'ha5a5_0001, 1, OUT_STORED, 0);
    add_row(0, k1, 200, 0, 0, 0, 1, OUT_MISS, 0);
    add_row(0, k1, 200, 0, 1, 0, 1, OUT_HIT, 32'ha5a5_0001);
    add_row(0, k1, 5100, 0, 1, 0, 1, OUT_STALE, 0);
    add_row(0, k1, 5100, 0, 1, 0, 1, OUT_MISS, 0);
    add_row(1, kone, 1000, 500, 1, 1, 1, OUT_REJECTED, 0);
    add_row(1, kone, 1000, 1000, 1, 1, 1, OUT_REJECTED, 0);
    add_row(1, kone, TimeTop, 0, 1, 1, 1, OUT_REJECTED, 0);
    add_row(1, kone, TimeTop - 1, 0, 1, '1, 1, OUT_STORED, 0);
    add_row(0, kone, TimeTop - 2, 0, 1, 0, 1, OUT_HIT, '1);
    add_row(1, '0, 2000, 2500, 1, 0, 0, OUT_STORED, 0);
    add_row(0, '0, 2499, 0, 1, 0, 0, OUT_HIT, 0);
    add_row(1, '0, 2100, TimeTop, 1, 32'h1234, 0, OUT_STORED, 0);
    add_row(0, '0, 7099, 0, 1, 0, 1, OUT_HIT, 32'h1234);
    add_row(1, k1, 3000, 3001, 1, 9, 0, OUT_STORED, 0);
    add_row(0, k1, 3001, 0, 1, 0, 1, OUT_STALE, 0);
    add_row(0, kone, TimeTop, 0, 1, 0, 1, OUT_STALE, 0);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    apb_access(1'b0, '0);

    foreach (directed[i]) begin
      w.outcome = directed[i].oc;
      w.context_out = directed[i].cx;
      send_item(directed[i].rq, directed[i].typed, w, ($urandom_range(0, 99) < 16) ? 2 : 0);
    end
    drain();

    ttl_list  = '{32'd5000, 32'd1, 32'hffff_ffff, 32'd0};
    phase_len = '{300, 150, 800, 450};
    base = 63'd10_000;
    item_no = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_ttl(ph == 3 ? $urandom_range(1, 20000) : ttl_list[ph]);
      for (int n = 0; n < phase_len[ph]; n++) begin
        if ($urandom_range(0, 99) >= 30) base += $urandom_range(1, 40);
        if ($urandom_range(0, 199) == 0) base += $urandom_range(1000, 30000);
        r = '0;
        r.action = $urandom_range(0, 99) < 55;
        r.eligible = $urandom_range(0, 99) < 92;
        if ($urandom_range(0, 99) < 85)
          {r.key_word3, r.key_word2, r.key_word1, r.key_word0} =
            key_pool[$urandom_range(0, NumKeys - 1)];
        else
          {r.key_word3, r.key_word2, r.key_word1, r.key_word0} =
            {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        // rare noise: a wild timestamp
        r.now_ms = ($urandom_range(0, 99) < 3) ? rand63() : base;
        case ($urandom_range(0, 19))
          0, 1, 2:    r.token_expiry_ms = r.now_ms + $urandom_range(1, 8000);
          3, 4:       r.token_expiry_ms = r.now_ms - $urandom_range(0, 50);
          5:          r.token_expiry_ms = rand63();
          default:    r.token_expiry_ms = '0;
        endcase
        r.context_in = $urandom();
        // hold off at random, except in a long quiet stretch
        gap = (item_no >= 600 && item_no < 900) ? 0 :
              (($urandom_range(0, 99) < 16) ? $urandom_range(1, 6) : 0);
        send_item(r, 1'b0, '0, gap);
        item_no++;
      end
      drain();
    end

    $display("covered %0d random items over four ttl settings, %0d result beats",
             item_no, beats_out);
    $display("hits %0d, stale removals %0d, evictions %0d", n_hit, n_stale, n_evict);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("ttl_cache_oldest_evict_top regression: pass");
    end else begin
      $display("ttl_cache_oldest_evict_top regression: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout at %0t", $realtime);
    $display("ttl_cache_oldest_evict_top regression: fail");
    $finish;
  end

endmodule
